### src/sgt_pkg.sv
// Shared types, constants and codes for the subscriber group table.
// Used by the controller, the datapath and the top level; depends on nothing.

package sgt_pkg;

  // Table dimensions
  localparam int NUM_TYPES      = 256;
  localparam int SUBS_PER_TYPE  = 16;
  localparam int CLIENT_ID_BITS = 10;
  localparam int MAX_RESULTS    = 16;

  // Port field widths
  localparam int ACTION_W    = 2;
  localparam int ID_PORT_W   = 10;
  localparam int TYPE_PORT_W = 8;
  localparam int LIMIT_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 9;

  // Derived widths
  localparam int TYPE_W = $clog2(NUM_TYPES);
  localparam int SLOT_W = (SUBS_PER_TYPE > 1) ? $clog2(SUBS_PER_TYPE) : 1;
  localparam int LEN_W  = $clog2(SUBS_PER_TYPE + 1);
  localparam int CHG_W  = $clog2(NUM_TYPES + 1);
  localparam int CMP_W  = ((LEN_W > LIMIT_W) ? LEN_W : LIMIT_W) + 1;

  typedef logic [CLIENT_ID_BITS-1:0] id_t;

  // One memory row holds a whole list and its length
  typedef struct packed {
    logic [LEN_W-1:0]               len;
    id_t [SUBS_PER_TYPE-1:0]        ent;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_DONE    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CHK,
    S_REM_RD,
    S_REM_RUN,
    S_REM_OUT,
    S_GET_RD,
    S_GET_CAP,
    S_GET_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted item, clear scan and tally
    logic rd_scan;     // read the row at the scan counter
    logic scan_step;   // process the scanned row, read the next one
    logic add_commit;  // decide the add, write the row, load the result
    logic rem_out;     // load the remove result
    logic get_cap;     // latch the listed row and its item count
    logic get_emit;    // load one list result item
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t in_action;
    logic    in_known;
    logic    out_free;
    logic    scan_last;
    logic    emit_last;
  } sts_t;

endpackage

### src/sgt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependency.

module sgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/sgt_ctrl.sv
// Sequencer for the subscriber group table: one item at a time.
// Depends on sgt_pkg for the state, command and status types.

module sgt_ctrl import sgt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!sts.in_known) begin
            state_next = S_IDLE;
          end else begin
            case (sts.in_action)
              ACT_ADD:    state_next = S_ADD_RD;
              ACT_REMOVE: state_next = S_REM_RD;
              ACT_LIST:   state_next = S_GET_RD;
              default:    state_next = S_IDLE;
            endcase
          end
        end
      end
      S_ADD_RD:   state_next = S_ADD_CHK;
      S_ADD_CHK:  if (sts.out_free) state_next = S_IDLE;
      S_REM_RD:   state_next = S_REM_RUN;
      S_REM_RUN:  if (sts.scan_last) state_next = S_REM_OUT;
      S_REM_OUT:  if (sts.out_free) state_next = S_IDLE;
      S_GET_RD:   state_next = S_GET_CAP;
      S_GET_CAP:  state_next = S_GET_EMIT;
      S_GET_EMIT: if (sts.out_free && sts.emit_last) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_ADD_RD:   cmd.add_commit = 1'b0;
      S_ADD_CHK:  cmd.add_commit = sts.out_free;
      S_REM_RD:   cmd.rd_scan    = 1'b1;
      S_REM_RUN:  cmd.scan_step  = 1'b1;
      S_REM_OUT:  cmd.rem_out    = sts.out_free;
      S_GET_RD:   cmd.get_cap    = 1'b0;
      S_GET_CAP:  cmd.get_cap    = 1'b1;
      S_GET_EMIT: cmd.get_emit   = sts.out_free;
      default:    cmd            = '0;
    endcase
  end

endmodule

### src/sgt_dp.sv
// Datapath: list memory, per-row valid bits, item registers and result register.
// Depends on sgt_pkg and sgt_ram.

module sgt_dp import sgt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [ACTION_W-1:0]    action,
  input  logic [ID_PORT_W-1:0]   client_id,
  input  logic [TYPE_PORT_W-1:0] stream_type,
  input  logic [LIMIT_W-1:0]     limit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic [ID_PORT_W-1:0]   subscriber_id,
  output logic                   item_valid,
  output logic [COUNT_W-1:0]     count,
  output logic                   last
);

  // Item registers
  id_t                    op_id;
  logic [TYPE_PORT_W-1:0] op_type;
  logic [LIMIT_W-1:0]     op_limit;
  logic [TYPE_W-1:0]      op_idx;
  logic                   op_in_range;

  // Scan and list registers
  logic [TYPE_W-1:0] scan;
  logic [CHG_W-1:0]  changed;
  row_t              get_row;
  logic [LEN_W-1:0]  get_cnt;
  logic [LEN_W-1:0]  emit;

  // Rows with a valid length; others read as empty
  logic [NUM_TYPES-1:0] row_ok;

  // Memory port signals
  logic              ram_we;
  logic [TYPE_W-1:0] ram_waddr;
  logic [TYPE_W-1:0] ram_raddr;
  row_t              ram_wdata;
  row_t              rd_row;
  logic [ROW_W-1:0]  ram_rdata;

  // Row evaluation
  logic              cur_ok;
  logic [LEN_W-1:0]  len_eff;
  logic [SUBS_PER_TYPE-1:0] hit;
  logic              any_hit;
  logic [SLOT_W-1:0] hit_idx;
  logic [LEN_W-1:0]  len_m1;
  row_t              add_row;
  row_t              rem_row;
  logic              add_full;
  logic              add_ok;
  status_t           add_status;
  logic [LIMIT_W-1:0] lim_c;
  logic [CMP_W-1:0]  len_x;
  logic [CMP_W-1:0]  lim_x;
  logic [LEN_W-1:0]  cnt_new;

  function automatic logic limit_gt_max(input logic [LIMIT_W-1:0] v);
    return (CMP_W'(v) > CMP_W'(MAX_RESULTS));
  endfunction

  assign op_idx      = op_type[TYPE_W-1:0];
  assign op_in_range = ({1'b0, op_type} < (TYPE_PORT_W + 1)'(NUM_TYPES));

  sgt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_TYPES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_row = ram_rdata;

  // Read address: the scan row when a scan opens, the next row during it, else the item's type
  always_comb begin
    if (cmd.scan_step) begin
      ram_raddr = TYPE_W'(scan + 1'b1);
    end else if (cmd.rd_scan) begin
      ram_raddr = scan;
    end else begin
      ram_raddr = op_idx;
    end
  end

  // Length of the row just read, and where the client sits in it
  always_comb begin
    cur_ok  = cmd.scan_step ? row_ok[scan] : (row_ok[op_idx] & op_in_range);
    len_eff = cur_ok ? rd_row.len : '0;
    len_m1  = len_eff - LEN_W'(1);
    for (int i = 0; i < SUBS_PER_TYPE; i++) begin
      hit[i] = (LEN_W'(i) < len_eff) && (rd_row.ent[i] == op_id);
    end
    any_hit = |hit;
    hit_idx = '0;
    for (int i = SUBS_PER_TYPE - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = SLOT_W'(i);
      end
    end
  end

  // Add: append when absent and room is left
  always_comb begin
    add_full = (len_eff >= LEN_W'(SUBS_PER_TYPE));
    add_ok   = op_in_range && !any_hit && !add_full;
    if (!op_in_range) begin
      add_status = ST_FULL;
    end else if (any_hit) begin
      add_status = ST_PRESENT;
    end else if (add_full) begin
      add_status = ST_FULL;
    end else begin
      add_status = ST_ADDED;
    end
    add_row = rd_row;
    add_row.len = len_eff + LEN_W'(1);
    add_row.ent[len_eff[SLOT_W-1:0]] = op_id;
  end

  // Remove: last entry moves into the hole
  always_comb begin
    rem_row = rd_row;
    rem_row.len = len_m1;
    rem_row.ent[hit_idx] = rd_row.ent[len_m1[SLOT_W-1:0]];
  end

  // Write port
  always_comb begin
    if (cmd.scan_step) begin
      ram_we    = any_hit;
      ram_waddr = scan;
      ram_wdata = rem_row;
    end else begin
      ram_we    = cmd.add_commit && add_ok;
      ram_waddr = op_idx;
      ram_wdata = add_row;
    end
  end

  // List item count: least of length, limit and result capacity
  always_comb begin
    lim_c   = (limit_gt_max(op_limit)) ? LIMIT_W'(MAX_RESULTS) : op_limit;
    len_x   = CMP_W'(len_eff);
    lim_x   = CMP_W'(lim_c);
    cnt_new = (len_x < lim_x) ? len_eff : LEN_W'(lim_c);
  end

  // Row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
    end else if (cmd.add_commit && add_ok) begin
      row_ok[op_idx] <= 1'b1;
    end
  end

  // Item capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_id    <= CLIENT_ID_BITS'(client_id);
      op_type  <= stream_type;
      op_limit <= limit;
      scan     <= '0;
      changed  <= '0;
    end else if (cmd.scan_step) begin
      scan <= TYPE_W'(scan + 1'b1);
      if (any_hit) begin
        changed <= CHG_W'(changed + 1'b1);
      end
    end
  end

  // List capture and emit index
  always_ff @(posedge clk) begin
    if (cmd.get_cap) begin
      get_row <= rd_row;
      get_cnt <= cnt_new;
      emit    <= '0;
    end else if (cmd.get_emit) begin
      emit <= LEN_W'(emit + 1'b1);
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.add_commit || cmd.rem_out || cmd.get_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      status        <= add_status;
      subscriber_id <= '0;
      item_valid    <= 1'b0;
      count         <= '0;
      last          <= 1'b1;
    end else if (cmd.rem_out) begin
      status        <= ST_DONE;
      subscriber_id <= '0;
      item_valid    <= 1'b0;
      count         <= COUNT_W'(changed);
      last          <= 1'b1;
    end else if (cmd.get_emit) begin
      status        <= ST_DONE;
      subscriber_id <= (get_cnt != '0) ? ID_PORT_W'(get_row.ent[emit[SLOT_W-1:0]]) : '0;
      item_valid    <= (get_cnt != '0);
      count         <= COUNT_W'(get_cnt);
      last          <= sts.emit_last;
    end
  end

  // Status to the controller
  always_comb begin
    sts.in_action = action_t'(action);
    sts.in_known  = (action == ACT_ADD) || (action == ACT_REMOVE) || (action == ACT_LIST);
    sts.out_free  = !out_valid || out_ready;
    sts.scan_last = (scan == TYPE_W'(NUM_TYPES - 1));
    sts.emit_last = (get_cnt == '0) || (LEN_W'(emit + 1'b1) == get_cnt);
  end

endmodule

### src/subscriber_group_table.sv
// Subscriber group table: per stream type, a compact list of up to SUBS_PER_TYPE client ids
// in one memory row. One item is worked at a time; the result register lets the next item in
// while the last result waits. A list gives its result items one after another, and
// remove-all reads one row per type through the single read port of the list memory.
// Lengths clear at reset through per-row valid bits, so no clearing pass is needed.
// Action code 3 is taken and dropped without a result.
// Depends on sgt_pkg, sgt_ctrl and sgt_dp.

module subscriber_group_table import sgt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACTION_W-1:0]    action,
  input  logic [ID_PORT_W-1:0]   client_id,
  input  logic [TYPE_PORT_W-1:0] stream_type,
  input  logic [LIMIT_W-1:0]     limit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic [ID_PORT_W-1:0]   subscriber_id,
  output logic                   item_valid,
  output logic [COUNT_W-1:0]     count,
  output logic                   last
);

  cmd_t cmd;
  sts_t sts;

  sgt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sgt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .client_id     (client_id),
    .stream_type   (stream_type),
    .limit         (limit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .subscriber_id (subscriber_id),
    .item_valid    (item_valid),
    .count         (count),
    .last          (last)
  );

`ifndef ASSERT_OFF
  // A listed subscriber only ever comes with the list status
  a_item_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_valid |-> status == ST_DONE)
    else $error("listed subscriber with add status");

  // Only list items carry no last marker, and each holds a subscriber
  a_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> item_valid && status == ST_DONE)
    else $error("non-final result item without subscriber");

  // Add results are single items with no count and no subscriber
  a_add_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ADDED || status == ST_PRESENT || status == ST_FULL)
    |-> last && !item_valid && count == '0)
    else $error("malformed add result");

  // An accepted remove closes the input as its scan begins
  a_rem_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_REMOVE |=> !in_ready)
    else $error("input open during remove scan");
`endif

endmodule

### verif/tb_subscriber_group_table.sv
// Self-checking testbench for subscriber_group_table: a directed table then random adds,
// removes, lists, dropped codes, checked item by item, mostly by a membership predictor.
// Depends on sgt_pkg and the subscriber_group_table RTL.

module tb_subscriber_group_table;
  import sgt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Action code the block takes and drops
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 155;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    status_t              st;
    logic [ID_PORT_W-1:0] sid;
    logic                 iv;
    logic [COUNT_W-1:0]   cnt;
    logic                 lst;
  } result_t;

  typedef struct {
    logic [ACTION_W-1:0]    act;
    logic [ID_PORT_W-1:0]   cid;
    logic [TYPE_PORT_W-1:0] styp;
    logic [LIMIT_W-1:0]     lim;
    bit                     typed;   // expectation written in the row
    status_t                st;
    logic [COUNT_W-1:0]     cnt;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ACTION_W-1:0]    action = '0;
  logic [ID_PORT_W-1:0]   client_id = '0;
  logic [TYPE_PORT_W-1:0] stream_type = '0;
  logic [LIMIT_W-1:0]     limit = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [ID_PORT_W-1:0]   subscriber_id;
  logic                   item_valid;
  logic [COUNT_W-1:0]     count;
  logic                   last;

  // Predictor state: a copy of every list and its length
  id_t              member_tab [NUM_TYPES][SUBS_PER_TYPE];
  logic [LEN_W-1:0] list_len [NUM_TYPES];
  result_t          answer_buf [MAX_RESULTS];
  result_t          pending_results [$];
  stim_row_t        directed_rows [$];
  int               mismatch_count = 0;

  subscriber_group_table uut (.*);

  always #4 clk = ~clk;

  // Run limit, well above the slowest legal run
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  function automatic result_t make_result(status_t st, logic [ID_PORT_W-1:0] sid,
                                          logic iv, logic [COUNT_W-1:0] cnt, logic lst);
    result_t r;
    r.st  = st;
    r.sid = sid;
    r.iv  = iv;
    r.cnt = cnt;
    r.lst = lst;
    return r;
  endfunction

  function automatic stim_row_t row(logic [ACTION_W-1:0] act, int cid, int styp, int lim,
                                    bit typed = 0, status_t st = ST_DONE, int cnt = 0);
    stim_row_t r;
    r.act   = act;
    r.cid   = ID_PORT_W'(cid);
    r.styp  = TYPE_PORT_W'(styp);
    r.lim   = LIMIT_W'(lim);
    r.typed = typed;
    r.st    = st;
    r.cnt   = COUNT_W'(cnt);
    return r;
  endfunction

  // Apply one accepted item to the membership copy; results land in answer_buf
  task automatic predict_membership(input logic [ACTION_W-1:0] act,
                                    input logic [ID_PORT_W-1:0] cid,
                                    input logic [TYPE_PORT_W-1:0] styp,
                                    input logic [LIMIT_W-1:0] lim, output int n);
    id_t                who;
    int                 t, len, take;
    logic [COUNT_W-1:0] changed;
    status_t            st;
    bit                 hit;
    who = id_t'(cid);
    t   = int'(styp);
    n   = 0;
    if (act == ACT_ADD) begin
      if (t >= NUM_TYPES) begin
        st = ST_FULL;
      end else begin
        len = int'(list_len[t]);
        hit = 0;
        for (int i = 0; i < len; i++)
          if (member_tab[t][i] == who) hit = 1;
        if (hit) begin
          st = ST_PRESENT;
        end else if (len >= SUBS_PER_TYPE) begin
          st = ST_FULL;
        end else begin
          member_tab[t][len] = who;
          list_len[t] = LEN_W'(len + 1);
          st = ST_ADDED;
        end
      end
      answer_buf[0] = make_result(st, '0, 1'b0, '0, 1'b1);
      n = 1;
    end else if (act == ACT_REMOVE) begin
      // Swap the list's tail into the hole, at most once per list
      changed = '0;
      for (int ty = 0; ty < NUM_TYPES; ty++) begin
        len = int'(list_len[ty]);
        for (int i = 0; i < len; i++) begin
          if (member_tab[ty][i] == who) begin
            member_tab[ty][i] = member_tab[ty][len-1];
            list_len[ty] = LEN_W'(len - 1);
            changed++;
            break;
          end
        end
      end
      answer_buf[0] = make_result(ST_DONE, '0, 1'b0, changed, 1'b1);
      n = 1;
    end else if (act == ACT_LIST) begin
      take = (t < NUM_TYPES) ? int'(list_len[t]) : 0;
      if (take > int'(lim)) take = int'(lim);
      if (take > MAX_RESULTS) take = MAX_RESULTS;
      if (take > SUBS_PER_TYPE) take = SUBS_PER_TYPE;
      if (take == 0) begin
        answer_buf[0] = make_result(ST_DONE, '0, 1'b0, '0, 1'b1);
        n = 1;
      end else begin
        for (int i = 0; i < take; i++)
          answer_buf[i] = make_result(ST_DONE, ID_PORT_W'(member_tab[t][i]), 1'b1,
                                      COUNT_W'(take), i == take - 1);
        n = take;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Mostly back-to-back items, some short pauses, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Present one item and hold it until taken
  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [ID_PORT_W-1:0] cid,
                              input logic [TYPE_PORT_W-1:0] styp,
                              input logic [LIMIT_W-1:0] lim);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    client_id   <= cid;
    stream_type <= styp;
    limit       <= lim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send an item and queue what it should produce
  task automatic issue(input stim_row_t r);
    int n;
    send_request(r.act, r.cid, r.styp, r.lim);
    predict_membership(r.act, r.cid, r.styp, r.lim, n);
    if (r.typed) begin
      pending_results.push_back(make_result(r.st, '0, 1'b0, r.cnt, 1'b1));
    end else begin
      for (int i = 0; i < n; i++) pending_results.push_back(answer_buf[i]);
    end
  endtask

  // Result side: long open stretches, random back-pressure, long stalls
  initial begin
    int r;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end else if (r < 90) begin
        repeat ($urandom_range(10, 30)) begin
          out_ready <= 1'($urandom_range(0, 1));
          @(posedge clk);
        end
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d id=%0d valid=%0d count=%0d",
                                  status, subscriber_id, item_valid, count));
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st)
          report_mismatch($sformatf("status %0d, wanted %0d", status, e.st));
        if (subscriber_id !== e.sid)
          report_mismatch($sformatf("subscriber_id %0d, wanted %0d", subscriber_id, e.sid));
        if (item_valid !== e.iv)
          report_mismatch($sformatf("item_valid %0d, wanted %0d", item_valid, e.iv));
        if (count !== e.cnt)
          report_mismatch($sformatf("count %0d, wanted %0d", count, e.cnt));
        if (last !== e.lst)
          report_mismatch($sformatf("last %0d, wanted %0d", last, e.lst));
      end
    end
  end

  // Stimulus
  initial begin
    id_t              id_pool [24];
    logic [TYPE_W-1:0] hot_types [3];
    stim_row_t        r;
    int               sent, pick;

    for (int t = 0; t < NUM_TYPES; t++) begin
      list_len[t] = '0;
      for (int i = 0; i < SUBS_PER_TYPE; i++) member_tab[t][i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: empty table, duplicates, extremes, a full list, the dropped code
    directed_rows.push_back(row(ACT_LIST, 0, 0, 16, 1, ST_DONE, 0));
    directed_rows.push_back(row(ACT_REMOVE, 5, 0, 0, 1, ST_DONE, 0));
    directed_rows.push_back(row(ACT_ADD, 0, 0, 0, 1, ST_ADDED));
    directed_rows.push_back(row(ACT_ADD, 0, 0, 0, 1, ST_PRESENT));
    directed_rows.push_back(row(ACT_ADD, 1023, 255, 31, 1, ST_ADDED));
    directed_rows.push_back(row(ACT_LIST, 0, 255, 0, 1, ST_DONE, 0));
    for (int i = 0; i < SUBS_PER_TYPE; i++)
      directed_rows.push_back(row(ACT_ADD, 1008 + i, 7, 0, 1, ST_ADDED));
    directed_rows.push_back(row(ACT_ADD, 0, 7, 0, 1, ST_FULL));
    directed_rows.push_back(row(ACT_LIST, 0, 7, 31));
    directed_rows.push_back(row(ACT_UNUSED, 1023, 255, 31));
    directed_rows.push_back(row(ACT_REMOVE, 1023, 0, 0, 1, ST_DONE, 2));
    directed_rows.push_back(row(ACT_LIST, 0, 7, 16));
    foreach (directed_rows[k]) issue(directed_rows[k]);

    // Random part: a few busy types and a pool of clients so lists fill and drain
    foreach (id_pool[k]) id_pool[k] = id_t'($urandom);
    foreach (hot_types[k]) hot_types[k] = TYPE_W'($urandom);
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) r.act = ACT_ADD;
      else if (pick < 70) r.act = ACT_REMOVE;
      else if (pick < 95) r.act = ACT_LIST;
      else r.act = ACT_UNUSED;
      r.cid   = ($urandom_range(0, 99) < 85) ? ID_PORT_W'(id_pool[$urandom_range(0, 23)])
                                             : ID_PORT_W'($urandom);
      r.styp  = ($urandom_range(0, 99) < 80) ? TYPE_PORT_W'(hot_types[$urandom_range(0, 2)])
                                             : TYPE_PORT_W'($urandom);
      r.lim   = ($urandom_range(0, 9) == 0) ? '0 : LIMIT_W'($urandom);
      r.typed = 0;
      issue(r);
      sent++;
    end
    in_valid <= 1'b0;

    // Drain, then allow for an item still being worked
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
src/sgt_pkg.sv
src/sgt_ram.sv
src/sgt_ctrl.sv
src/sgt_dp.sv
src/subscriber_group_table.sv
verif/tb_subscriber_group_table.sv
